// ===== hw/rtl/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescape and UTF-8 check block.
package jsu_pkg;

    localparam int COUNT_BITS = 24;
    localparam int CFG_BITS   = 24;
    localparam int SUM_BITS   = ((COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS) + 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;
    localparam logic [CFG_BITS-1:0]   CFG_MAX_RST = CFG_BITS'(65535);

    typedef enum logic [3:0] {
        ST_DATA          = 4'd0,
        ST_DONE          = 4'd1,
        ST_NO_QUOTE      = 4'd2,
        ST_CTRL_CHAR     = 4'd3,
        ST_BAD_ESCAPE    = 4'd4,
        ST_BAD_HEX       = 4'd5,
        ST_HIGH_UNPAIRED = 4'd6,
        ST_LOW_RANGE     = 4'd7,
        ST_LONE_LOW      = 4'd8,
        ST_BAD_UTF8      = 4'd9,
        ST_TOO_LONG      = 4'd10,
        ST_UNTERMINATED  = 4'd11
    } t_status;

    // All words caused by one input item: n words, bytes[0] goes out first.
    typedef struct packed {
        logic [2:0]      n;
        t_status         status;
        logic [3:0][7:0] bytes;
    } t_bundle;

endpackage

// ===== hw/rtl/jsu_if.sv =====
// Channel interfaces: input items, result words and configuration writes.
interface jsu_item_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] byte_in;

    modport source (output valid, kind, byte_in, input ready);
    modport sink   (input valid, kind, byte_in, output ready);
endinterface

interface jsu_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [3:0] status;
    logic       last;

    modport source (output valid, out_byte, status, last, input ready);
    modport sink   (input valid, out_byte, status, last, output ready);
endinterface

interface jsu_cfg_if;
    import jsu_pkg::*;
    logic                valid;
    logic                ready;
    logic [CFG_BITS-1:0] max_len;

    modport source (output valid, max_len, input ready);
    modport sink   (input valid, max_len, output ready);
endinterface

// ===== hw/rtl/jsu_decode.sv =====
// Per-item decoder: parse state, escape and UTF-8 logic, byte limit check.
module jsu_decode (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic                          i_kind,
    input  logic [7:0]                    i_byte,
    input  logic [jsu_pkg::CFG_BITS-1:0]  i_max,
    output logic                          o_emit,
    output jsu_pkg::t_bundle              o_bundle
);
    import jsu_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_BODY, PH_ESC, PH_HEX1, PH_SBS, PH_SU, PH_HEX2, PH_UTF8, PH_DONE, PH_ERR
    } t_phase;

    typedef struct packed {
        logic [2:0]      n;
        logic [3:0][7:0] b;
    } t_enc;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    function automatic t_enc encode(input logic [20:0] cp);
        t_enc e;
        e.b = '0;
        if (cp < 21'h80) begin
            e.n = 3'd1;
            e.b[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            e.n = 3'd2;
            e.b[0] = {3'b110, cp[10:6]};
            e.b[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            e.n = 3'd3;
            e.b[0] = {4'b1110, cp[15:12]};
            e.b[1] = {2'b10, cp[11:6]};
            e.b[2] = {2'b10, cp[5:0]};
        end else begin
            e.n = 3'd4;
            e.b[0] = {5'b11110, cp[20:18]};
            e.b[1] = {2'b10, cp[17:12]};
            e.b[2] = {2'b10, cp[11:6]};
            e.b[3] = {2'b10, cp[5:0]};
        end
        return e;
    endfunction

    t_phase                r_phase, n_phase;
    logic [1:0]            r_hex_cnt, n_hex_cnt;
    logic [15:0]           r_code, n_code;
    logic [9:0]            r_high, n_high;
    logic [1:0]            r_urem, n_urem;
    logic [2:0]            r_ulen, n_ulen;
    logic [20:0]           r_uval, n_uval;
    logic [2:0][7:0]       r_held, n_held;
    logic [COUNT_BITS-1:0] r_count, n_count;

    logic [4:0]            hv;
    logic [15:0]           unit;
    logic [20:0]           cp;
    t_enc                  enc;
    logic [20:0]           cont_val;
    logic [2:0]            got;
    logic [20:0]           minimum;
    logic                  rel;
    logic [2:0]            rel_n;
    logic [3:0][7:0]       rel_b;
    logic [SUM_BITS-1:0]   total;
    t_status               e_status;
    logic                  emit;

    always_comb begin
        n_phase   = r_phase;
        n_hex_cnt = r_hex_cnt;
        n_code    = r_code;
        n_high    = r_high;
        n_urem    = r_urem;
        n_ulen    = r_ulen;
        n_uval    = r_uval;
        n_held    = r_held;
        n_count   = r_count;
        emit      = 1'b0;
        e_status  = ST_DATA;
        rel       = 1'b0;
        rel_n     = 3'd0;
        rel_b     = '0;

        hv       = hex_val(i_byte);
        unit     = {r_code[11:0], hv[3:0]};
        // A surrogate pair adds 0x10000 to the ten payload bits of each half.
        cp       = (r_phase == PH_HEX2) ? (21'h10000 + {1'b0, r_high, unit[9:0]})
                                        : {5'd0, unit};
        enc      = encode(cp);
        cont_val = {r_uval[14:0], i_byte[5:0]};
        got      = r_ulen - {1'b0, r_urem};
        minimum  = (r_ulen == 3'd2) ? 21'h80 : ((r_ulen == 3'd3) ? 21'h800 : 21'h10000);

        if (i_fire && i_kind) begin
            unique case (r_phase)
                PH_IDLE: begin
                    emit = 1'b1;
                    e_status = ST_NO_QUOTE;
                end
                PH_BODY, PH_ESC, PH_HEX1: begin
                    emit = 1'b1;
                    e_status = ST_UNTERMINATED;
                end
                PH_SBS, PH_SU, PH_HEX2: begin
                    emit = 1'b1;
                    e_status = ST_HIGH_UNPAIRED;
                end
                PH_UTF8: begin
                    emit = 1'b1;
                    e_status = ST_BAD_UTF8;
                end
                default: emit = 1'b0;
            endcase
            n_phase   = PH_IDLE;
            n_hex_cnt = 2'd0;
            n_code    = 16'd0;
            n_high    = 10'd0;
            n_urem    = 2'd0;
            n_ulen    = 3'd0;
            n_uval    = 21'd0;
            n_count   = '0;
        end else if (i_fire) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_byte != CH_QUOTE) begin
                        emit = 1'b1;
                        e_status = ST_NO_QUOTE;
                        n_phase = PH_ERR;
                    end else begin
                        n_phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (i_byte == CH_QUOTE) begin
                        emit = 1'b1;
                        e_status = ST_DONE;
                        n_phase = PH_DONE;
                    end else if (i_byte < 8'h20) begin
                        emit = 1'b1;
                        e_status = ST_CTRL_CHAR;
                        n_phase = PH_ERR;
                    end else if (i_byte == CH_BSL) begin
                        n_phase = PH_ESC;
                    end else if (i_byte < 8'h80) begin
                        rel = 1'b1;
                        rel_n = 3'd1;
                        rel_b[0] = i_byte;
                    end else if (i_byte[7:5] == 3'b110 || i_byte[7:4] == 4'b1110
                                 || i_byte[7:3] == 5'b11110) begin
                        if (i_byte[7:5] == 3'b110) begin
                            n_ulen = 3'd2;
                            n_uval = {16'd0, i_byte[4:0]};
                        end else if (i_byte[7:4] == 4'b1110) begin
                            n_ulen = 3'd3;
                            n_uval = {17'd0, i_byte[3:0]};
                        end else begin
                            n_ulen = 3'd4;
                            n_uval = {18'd0, i_byte[2:0]};
                        end
                        n_held[0] = i_byte;
                        n_urem = 2'(n_ulen - 3'd1);
                        n_phase = PH_UTF8;
                    end else begin
                        emit = 1'b1;
                        e_status = ST_BAD_UTF8;
                        n_phase = PH_ERR;
                    end
                end
                PH_ESC: begin
                    rel = 1'b1;
                    rel_n = 3'd1;
                    unique case (i_byte)
                        CH_QUOTE: rel_b[0] = CH_QUOTE;
                        CH_BSL:   rel_b[0] = CH_BSL;
                        CH_SLASH: rel_b[0] = CH_SLASH;
                        CH_B:     rel_b[0] = 8'h08;
                        CH_F:     rel_b[0] = 8'h0C;
                        CH_N:     rel_b[0] = 8'h0A;
                        CH_R:     rel_b[0] = 8'h0D;
                        CH_T:     rel_b[0] = 8'h09;
                        CH_U: begin
                            rel = 1'b0;
                            n_hex_cnt = 2'd0;
                            n_code = 16'd0;
                            n_phase = PH_HEX1;
                        end
                        default: begin
                            rel = 1'b0;
                            emit = 1'b1;
                            e_status = ST_BAD_ESCAPE;
                            n_phase = PH_ERR;
                        end
                    endcase
                end
                PH_HEX1, PH_HEX2: begin
                    if (!hv[4]) begin
                        emit = 1'b1;
                        e_status = ST_BAD_HEX;
                        n_phase = PH_ERR;
                    end else begin
                        n_code = unit;
                        if (r_hex_cnt != 2'd3) begin
                            n_hex_cnt = r_hex_cnt + 2'd1;
                        end else begin
                            n_hex_cnt = 2'd0;
                            if (r_phase == PH_HEX2) begin
                                if (unit < 16'hDC00 || unit > 16'hDFFF) begin
                                    emit = 1'b1;
                                    e_status = ST_LOW_RANGE;
                                    n_phase = PH_ERR;
                                end else begin
                                    rel = 1'b1;
                                    rel_n = enc.n;
                                    rel_b = enc.b;
                                end
                            end else if (unit >= 16'hD800 && unit <= 16'hDBFF) begin
                                n_high = unit[9:0];
                                n_phase = PH_SBS;
                            end else if (unit >= 16'hDC00 && unit <= 16'hDFFF) begin
                                emit = 1'b1;
                                e_status = ST_LONE_LOW;
                                n_phase = PH_ERR;
                            end else begin
                                rel = 1'b1;
                                rel_n = enc.n;
                                rel_b = enc.b;
                            end
                        end
                    end
                end
                PH_SBS: begin
                    if (i_byte != CH_BSL) begin
                        emit = 1'b1;
                        e_status = ST_HIGH_UNPAIRED;
                        n_phase = PH_ERR;
                    end else begin
                        n_phase = PH_SU;
                    end
                end
                PH_SU: begin
                    if (i_byte != CH_U) begin
                        emit = 1'b1;
                        e_status = ST_HIGH_UNPAIRED;
                        n_phase = PH_ERR;
                    end else begin
                        n_hex_cnt = 2'd0;
                        n_code = 16'd0;
                        n_phase = PH_HEX2;
                    end
                end
                PH_UTF8: begin
                    if (i_byte[7:6] != 2'b10) begin
                        emit = 1'b1;
                        e_status = ST_BAD_UTF8;
                        n_phase = PH_ERR;
                    end else begin
                        n_uval = cont_val;
                        n_urem = r_urem - 2'd1;
                        if (n_urem != 2'd0) begin
                            if (got == 3'd1) n_held[1] = i_byte;
                            else if (got == 3'd2) n_held[2] = i_byte;
                        end else if (cont_val < minimum
                                     || (cont_val >= 21'h00D800 && cont_val <= 21'h00DFFF)
                                     || cont_val > 21'h10FFFF) begin
                            emit = 1'b1;
                            e_status = ST_BAD_UTF8;
                            n_phase = PH_ERR;
                        end else begin
                            rel = 1'b1;
                            rel_n = r_ulen;
                            rel_b[0] = r_held[0];
                            if (r_ulen == 3'd2) begin
                                rel_b[1] = i_byte;
                            end else if (r_ulen == 3'd3) begin
                                rel_b[1] = r_held[1];
                                rel_b[2] = i_byte;
                            end else begin
                                rel_b[1] = r_held[1];
                                rel_b[2] = r_held[2];
                                rel_b[3] = i_byte;
                            end
                        end
                    end
                end
                default: emit = 1'b0;
            endcase
        end

        total = SUM_BITS'(r_count) + SUM_BITS'(rel_n);
        if (rel) begin
            emit = 1'b1;
            if (total > SUM_BITS'(i_max)) begin
                e_status = ST_TOO_LONG;
                n_phase = PH_ERR;
            end else begin
                n_count = (total > SUM_BITS'(COUNT_MAX)) ? COUNT_MAX : COUNT_BITS'(total);
                n_phase = PH_BODY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_hex_cnt <= 2'd0;
            r_code    <= 16'd0;
            r_high    <= 10'd0;
            r_urem    <= 2'd0;
            r_ulen    <= 3'd0;
            r_uval    <= 21'd0;
            r_count   <= '0;
        end else begin
            r_phase   <= n_phase;
            r_hex_cnt <= n_hex_cnt;
            r_code    <= n_code;
            r_high    <= n_high;
            r_urem    <= n_urem;
            r_ulen    <= n_ulen;
            r_uval    <= n_uval;
            r_count   <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

    assign o_emit          = emit;
    assign o_bundle.status = e_status;
    assign o_bundle.n      = (e_status == ST_DATA) ? rel_n : 3'd1;
    assign o_bundle.bytes  = (e_status == ST_DATA) ? rel_b : '0;

endmodule

// ===== hw/rtl/jsu_serial.sv =====
// Output stage: holds the words of one item and sends them one per cycle while ready.
module jsu_serial (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  jsu_pkg::t_bundle     i_bundle,
    output logic                 o_free,
    jsu_result_if.source         o_out
);
    import jsu_pkg::*;

    logic       r_valid;
    logic [1:0] r_idx;
    t_bundle    r_bundle;
    logic       last;

    assign last = ({1'b0, r_idx} + 3'd1) == r_bundle.n;

    // The stage can take a new item while its final word leaves.
    assign o_free = !r_valid || (o_out.ready && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (r_valid && o_out.ready) begin
            if (last) r_valid <= 1'b0;
            else      r_idx   <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) r_bundle <= i_bundle;
    end

    assign o_out.valid    = r_valid;
    assign o_out.out_byte = (r_bundle.status == ST_DATA) ? r_bundle.bytes[r_idx] : 8'd0;
    assign o_out.status   = r_bundle.status;
    assign o_out.last     = last;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_bundle.n != 3'd0 && r_bundle.n <= 3'd4))
        else $error("word count of held item out of range");
    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_bundle.status != ST_DATA) |-> (r_bundle.n == 3'd1))
        else $error("status word is not alone");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ({1'b0, r_idx} < r_bundle.n))
        else $error("word index past item end");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("item loaded over unsent words");
`endif

endmodule

// ===== hw/rtl/json_string_unescape_validate.sv =====
// Top level: input register, limit register, decoder and output stage.
//
//  channel  dir  word contents                       completes when
//  i_in     in   kind, byte_in                       valid & ready
//  o_out    out  out_byte, status, last              valid & ready
//  i_cfg    in   max_len (24 bits)                   valid & ready (ready always high)
//
// An item enters the input register and is decoded once the output stage is free;
// its words appear in the next cycle. An item yields up to 4 words; the rate is one
// item per cycle when each item yields at most one word and the output is not
// stalled. A stalled output holds the input register, and input ready then drops.
// Reset clears all control state and sets the limit to 65535.
module json_string_unescape_validate (
    input  logic         i_clk,
    input  logic         i_rst_n,
    jsu_item_if.sink     i_in,
    jsu_result_if.source o_out,
    jsu_cfg_if.sink      i_cfg
);
    import jsu_pkg::*;

    logic                r_in_valid;
    logic                r_in_kind;
    logic [7:0]          r_in_byte;
    logic [CFG_BITS-1:0] r_max;
    logic                ser_free;
    logic                fire;
    logic                dec_emit;
    t_bundle             dec_bundle;

    assign fire        = r_in_valid && ser_free;
    assign i_in.ready  = !r_in_valid || fire;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_max      <= CFG_MAX_RST;
        end else begin
            if (i_in.valid && i_in.ready) r_in_valid <= 1'b1;
            else if (fire)                r_in_valid <= 1'b0;
            if (i_cfg.valid) r_max <= i_cfg.max_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_kind <= i_in.kind;
            r_in_byte <= i_in.byte_in;
        end
    end

    jsu_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_kind   (r_in_kind),
        .i_byte   (r_in_byte),
        .i_max    (r_max),
        .o_emit   (dec_emit),
        .o_bundle (dec_bundle)
    );

    jsu_serial u_serial (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire && dec_emit),
        .i_bundle (dec_bundle),
        .o_free   (ser_free),
        .o_out    (o_out)
    );

`ifndef SYNTHESIS
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !ser_free) |=> (r_in_valid && $stable(r_in_kind)
                                       && $stable(r_in_byte)))
        else $error("buffered item lost while output stalled");
    a_no_take_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !fire) |-> !i_in.ready)
        else $error("input taken over an undecoded item");
    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && dec_emit) |=> o_out.valid)
        else $error("decoded words not presented");
`endif

endmodule

// ===== tb/sv/json_string_unescape_validate_tb.sv =====
// Testbench for the JSON string unescape and UTF-8 check block, with its own decoder model.
module json_string_unescape_validate_tb;
    import jsu_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 60;
    localparam int LIMIT_CYCLES  = 200000;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [23:0] LIMIT_TOP = 24'hFFFFFF;

    typedef enum logic [3:0] {
        WAIT_QUOTE, IN_BODY, AFTER_BSLASH, FIRST_HEX, WANT_BSLASH,
        WANT_U, SECOND_HEX, IN_SEQ, FINISHED, FAILED
    } t_dec_phase;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
    } t_in_word;

    typedef struct packed {
        logic [7:0] data;
        t_status    status;
        logic       last;
    } t_out_word;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    jsu_item_if   in_if ();
    jsu_result_if out_if ();
    jsu_cfg_if    cfg_if ();

    json_string_unescape_validate i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Decoder model state.
    logic [23:0] byte_limit;
    t_dec_phase  ph;
    logic [1:0]  hex_seen;
    logic [15:0] unit_acc;
    logic [15:0] high_unit;
    logic [1:0]  seq_left;
    logic [2:0]  seq_len;
    logic [20:0] seq_val;
    logic [7:0]  seq_held [3];
    logic [23:0] out_count;

    t_out_word expected_words [$];
    t_in_word  item_q [$];
    int        made_cnt      = 0;
    int        accepted_cnt  = 0;
    int        fail_cnt      = 0;
    int        send_idle_pct = 34;
    int        recv_idle_pct = 46;
    int        hold_reqs     = 0;
    int        hold_seen     = 0;
    int        hold_left     = 0;

    function automatic void clear_decoder();
        ph        = WAIT_QUOTE;
        hex_seen  = '0;
        unit_acc  = '0;
        high_unit = '0;
        seq_left  = '0;
        seq_len   = '0;
        seq_val   = '0;
        out_count = '0;
        for (int k = 0; k < 3; k++) seq_held[k] = '0;
    endfunction

    function automatic void push_status(input t_status s);
        expected_words.insert(expected_words.size(), t_out_word'{8'h00, s, 1'b1});
    endfunction

    function automatic void fail_with(input t_status s);
        ph = FAILED;
        push_status(s);
    endfunction

    function automatic int utf8_encode(input logic [20:0] cp, output logic [3:0][7:0] b);
        b = '0;
        if (cp < 21'h80) begin
            b[0] = cp[7:0];
            return 1;
        end
        if (cp < 21'h800) begin
            b[0] = 8'hC0 | cp[10:6];
            b[1] = 8'h80 | cp[5:0];
            return 2;
        end
        if (cp < 21'h10000) begin
            b[0] = 8'hE0 | cp[15:12];
            b[1] = 8'h80 | cp[11:6];
            b[2] = 8'h80 | cp[5:0];
            return 3;
        end
        b[0] = 8'hF0 | cp[20:18];
        b[1] = 8'h80 | cp[17:12];
        b[2] = 8'h80 | cp[11:6];
        b[3] = 8'h80 | cp[5:0];
        return 4;
    endfunction

    // Bit 4 set means the byte is not a hex digit.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
        if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 10)};
        if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 10)};
        return 5'h10;
    endfunction

    // A decoded unit is only released if the whole unit fits under the limit.
    function automatic void release_bytes(input logic [3:0][7:0] b, input int n);
        logic [24:0] total;
        total = {1'b0, out_count} + 25'(n);
        if (total > {1'b0, byte_limit}) begin
            fail_with(ST_TOO_LONG);
            return;
        end
        out_count = (total > {1'b0, LIMIT_TOP}) ? LIMIT_TOP : total[23:0];
        for (int k = 0; k < n; k++)
            expected_words.insert(expected_words.size(),
                                  t_out_word'{b[k], ST_DATA, k == n - 1});
        ph = IN_BODY;
    endfunction

    function automatic void take_hex(input logic [7:0] c, input logic second);
        logic [4:0]      d;
        logic [3:0][7:0] b;
        logic [20:0]     cp;
        int              n;
        d = hex_nibble(c);
        if (d[4]) begin
            fail_with(ST_BAD_HEX);
            return;
        end
        unit_acc = {unit_acc[11:0], d[3:0]};
        if (hex_seen != 2'd3) begin
            hex_seen++;
            return;
        end
        hex_seen = '0;
        if (second) begin
            if (unit_acc < 16'hDC00 || unit_acc > 16'hDFFF) begin
                fail_with(ST_LOW_RANGE);
                return;
            end
            cp = 21'h10000 + {high_unit[9:0], unit_acc[9:0]};
        end else if (unit_acc >= 16'hD800 && unit_acc <= 16'hDBFF) begin
            high_unit = unit_acc;
            ph = WANT_BSLASH;
            return;
        end else if (unit_acc >= 16'hDC00 && unit_acc <= 16'hDFFF) begin
            fail_with(ST_LONE_LOW);
            return;
        end else begin
            cp = {5'b0, unit_acc};
        end
        n = utf8_encode(cp, b);
        release_bytes(b, n);
    endfunction

    function automatic void take_cont(input logic [7:0] c);
        logic [3:0][7:0] b;
        logic [2:0]      pos;
        logic [20:0]     floor_val;
        if (c[7:6] != 2'b10) begin
            fail_with(ST_BAD_UTF8);
            return;
        end
        seq_val  = {seq_val[14:0], c[5:0]};
        pos      = seq_len - {1'b0, seq_left};
        seq_left = seq_left - 2'd1;
        if (seq_left != 0) begin
            if (pos < 3) seq_held[pos] = c;
            return;
        end
        floor_val = (seq_len == 3'd2) ? 21'h80 : (seq_len == 3'd3) ? 21'h800 : 21'h10000;
        if (seq_val < floor_val || (seq_val >= 21'hD800 && seq_val <= 21'hDFFF) ||
            seq_val > 21'h10FFFF) begin
            fail_with(ST_BAD_UTF8);
            return;
        end
        b = '0;
        for (int k = 0; k < 3; k++)
            if (k + 1 < seq_len) b[k] = seq_held[k];
        b[seq_len - 3'd1] = c;
        release_bytes(b, int'(seq_len));
    endfunction

    // Works out the words that one accepted input item causes.
    function automatic void unescape_predict(input logic kind, input logic [7:0] c);
        logic [3:0][7:0] b;
        logic            esc_ok;
        int              lead_len;
        if (kind) begin
            case (ph)
                WAIT_QUOTE: push_status(ST_NO_QUOTE);
                IN_BODY, AFTER_BSLASH, FIRST_HEX: push_status(ST_UNTERMINATED);
                WANT_BSLASH, WANT_U, SECOND_HEX: push_status(ST_HIGH_UNPAIRED);
                IN_SEQ: push_status(ST_BAD_UTF8);
                default: ;
            endcase
            clear_decoder();
            return;
        end
        b = '0;
        case (ph)
            WAIT_QUOTE: begin
                if (c == CH_QUOTE) ph = IN_BODY;
                else fail_with(ST_NO_QUOTE);
            end
            IN_BODY: begin
                if (c == CH_QUOTE) begin
                    ph = FINISHED;
                    push_status(ST_DONE);
                end else if (c < 8'h20) begin
                    fail_with(ST_CTRL_CHAR);
                end else if (c == CH_BSLASH) begin
                    ph = AFTER_BSLASH;
                end else if (c < 8'h80) begin
                    b[0] = c;
                    release_bytes(b, 1);
                end else begin
                    lead_len = (c[7:5] == 3'b110) ? 2 : (c[7:4] == 4'b1110) ? 3 :
                               (c[7:3] == 5'b11110) ? 4 : 0;
                    if (lead_len == 0) begin
                        fail_with(ST_BAD_UTF8);
                    end else begin
                        seq_len     = 3'(lead_len);
                        seq_val     = (lead_len == 2) ? {16'b0, c[4:0]} :
                                      (lead_len == 3) ? {17'b0, c[3:0]} : {18'b0, c[2:0]};
                        seq_held[0] = c;
                        seq_left    = 2'(lead_len - 1);
                        ph          = IN_SEQ;
                    end
                end
            end
            AFTER_BSLASH: begin
                esc_ok = 1'b1;
                case (c)
                    CH_QUOTE, CH_BSLASH, "/": b[0] = c;
                    "b": b[0] = 8'h08;
                    "f": b[0] = 8'h0C;
                    "n": b[0] = 8'h0A;
                    "r": b[0] = 8'h0D;
                    "t": b[0] = 8'h09;
                    default: esc_ok = 1'b0;
                endcase
                if (c == CH_U) begin
                    hex_seen = '0;
                    unit_acc = '0;
                    ph       = FIRST_HEX;
                end else if (esc_ok) begin
                    release_bytes(b, 1);
                end else begin
                    fail_with(ST_BAD_ESCAPE);
                end
            end
            FIRST_HEX:  take_hex(c, 1'b0);
            SECOND_HEX: take_hex(c, 1'b1);
            WANT_BSLASH: begin
                if (c != CH_BSLASH) fail_with(ST_HIGH_UNPAIRED);
                else ph = WANT_U;
            end
            WANT_U: begin
                if (c != CH_U) begin
                    fail_with(ST_HIGH_UNPAIRED);
                end else begin
                    hex_seen = '0;
                    unit_acc = '0;
                    ph       = SECOND_HEX;
                end
            end
            IN_SEQ: take_cont(c);
            default: ;
        endcase
    endfunction

    // Stimulus building.
    function automatic void put_byte(input logic [7:0] b);
        item_q.insert(item_q.size(), t_in_word'{1'b0, b});
        made_cnt++;
    endfunction

    function automatic void put_end();
        item_q.insert(item_q.size(), t_in_word'{1'b1, 8'($urandom_range(0, 255))});
        made_cnt++;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'("0" + v);
        return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
    endfunction

    function automatic logic [7:0] rand_hex();
        return hex_char(4'($urandom_range(0, 15)));
    endfunction

    function automatic logic [7:0] rand_cont();
        return 8'($urandom_range(8'h80, 8'hBF));
    endfunction

    function automatic logic [15:0] rand_high();
        return 16'($urandom_range(16'hD800, 16'hDBFF));
    endfunction

    function automatic void put_u(input logic [15:0] u);
        put_byte(CH_BSLASH);
        put_byte(CH_U);
        for (int k = 3; k >= 0; k--) put_byte(hex_char(u[4*k +: 4]));
    endfunction

    // Scalar value whose UTF-8 form takes nbytes bytes, ends of the range now and then.
    function automatic logic [20:0] rand_scalar(input int nbytes);
        logic [20:0] lo;
        logic [20:0] hi;
        logic [20:0] v;
        lo = (nbytes == 1) ? 21'h0 : (nbytes == 2) ? 21'h80 : (nbytes == 3) ? 21'h800 : 21'h10000;
        hi = (nbytes == 1) ? 21'h7F : (nbytes == 2) ? 21'h7FF : (nbytes == 3) ? 21'hFFFF : 21'h10FFFF;
        case ($urandom_range(0, 7))
            0: v = lo;
            1: v = hi;
            default: v = 21'($urandom_range(lo, hi));
        endcase
        if (v >= 21'hD800 && v <= 21'hDFFF) v = v - 21'h800;
        return v;
    endfunction

    function automatic void put_unit();
        logic [7:0]      x;
        logic [3:0][7:0] b;
        int              n;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                do x = 8'($urandom_range(8'h20, 8'h7F));
                while (x == CH_QUOTE || x == CH_BSLASH);
                put_byte(x);
            end
            4: begin
                case ($urandom_range(0, 7))
                    0: x = CH_QUOTE;
                    1: x = CH_BSLASH;
                    2: x = "/";
                    3: x = "b";
                    4: x = "f";
                    5: x = "n";
                    6: x = "r";
                    default: x = "t";
                endcase
                put_byte(CH_BSLASH);
                put_byte(x);
            end
            5: put_u(16'(rand_scalar($urandom_range(1, 3))));
            6: begin
                put_u(rand_high());
                put_u(16'($urandom_range(16'hDC00, 16'hDFFF)));
            end
            default: begin
                n = utf8_encode(rand_scalar($urandom_range(2, 4)), b);
                for (int k = 0; k < n; k++) put_byte(b[k]);
            end
        endcase
    endfunction

    // Puts one malformed unit; returns 1 when end of input has to follow at once.
    function automatic logic put_fault();
        logic [7:0] x;
        logic [4:0] d;
        int         k;
        case ($urandom_range(0, 13))
            0: put_byte(8'($urandom_range(0, 31)));
            1: begin
                do x = 8'($urandom_range(0, 255));
                while (x == CH_QUOTE || x == CH_BSLASH || x == "/" || x == "b" || x == "f" ||
                       x == "n" || x == "r" || x == "t" || x == CH_U);
                put_byte(CH_BSLASH);
                put_byte(x);
            end
            2: begin
                put_byte(CH_BSLASH);
                put_byte(CH_U);
                repeat ($urandom_range(0, 3)) put_byte(rand_hex());
                do begin
                    x = 8'($urandom_range(0, 255));
                    d = hex_nibble(x);
                end while (!d[4]);
                put_byte(x);
            end
            3: put_u(16'($urandom_range(16'hDC00, 16'hDFFF)));
            4: begin
                put_u(rand_high());
                do x = 8'($urandom_range(0, 255));
                while (x == CH_BSLASH);
                put_byte(x);
            end
            5: begin
                put_u(rand_high());
                put_byte(CH_BSLASH);
                do x = 8'($urandom_range(0, 255));
                while (x == CH_U);
                put_byte(x);
            end
            6: begin
                put_u(rand_high());
                put_u($urandom_range(0, 1) ? 16'($urandom_range(0, 16'hDBFF))
                                           : 16'($urandom_range(16'hE000, 16'hFFFF)));
            end
            7: put_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                             : 8'($urandom_range(8'hF8, 8'hFF)));
            8: begin
                put_byte(8'($urandom_range(8'hC0, 8'hC1)));
                put_byte(rand_cont());
            end
            9: begin
                if ($urandom_range(0, 1)) begin
                    put_byte(8'hE0);
                    put_byte(8'($urandom_range(8'h80, 8'h9F)));
                    put_byte(rand_cont());
                end else begin
                    put_byte(8'hF0);
                    put_byte(8'($urandom_range(8'h80, 8'h8F)));
                    put_byte(rand_cont());
                    put_byte(rand_cont());
                end
            end
            10: begin
                put_byte(8'hED);
                put_byte(8'($urandom_range(8'hA0, 8'hBF)));
                put_byte(rand_cont());
            end
            11: begin
                if ($urandom_range(0, 1)) begin
                    put_byte(8'hF4);
                    put_byte(8'($urandom_range(8'h90, 8'hBF)));
                end else begin
                    put_byte(8'($urandom_range(8'hF5, 8'hF7)));
                    put_byte(rand_cont());
                end
                put_byte(rand_cont());
                put_byte(rand_cont());
            end
            12: begin
                put_byte(8'($urandom_range(8'hC2, 8'hF4)));
                do x = 8'($urandom_range(0, 255));
                while (x[7:6] == 2'b10);
                put_byte(x);
            end
            default: begin
                // Input ends inside an escape, a surrogate pair or a raw sequence.
                case ($urandom_range(0, 3))
                    0: put_byte(CH_BSLASH);
                    1: begin
                        put_byte(CH_BSLASH);
                        put_byte(CH_U);
                        repeat ($urandom_range(0, 3)) put_byte(rand_hex());
                    end
                    2: begin
                        put_u(rand_high());
                        k = $urandom_range(0, 2);
                        if (k > 0) put_byte(CH_BSLASH);
                        if (k > 1) begin
                            put_byte(CH_U);
                            repeat ($urandom_range(0, 3)) put_byte(rand_hex());
                        end
                    end
                    default: begin
                        k = $urandom_range(2, 4);
                        put_byte((k == 2) ? 8'($urandom_range(8'hC2, 8'hDF)) :
                                 (k == 3) ? 8'($urandom_range(8'hE1, 8'hEC)) :
                                            8'($urandom_range(8'hF1, 8'hF3)));
                        repeat ($urandom_range(0, k - 2)) put_byte(rand_cont());
                    end
                endcase
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    // One token: mostly well-formed strings with random content, some broken, some noise.
    function automatic void add_token();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6) begin
            repeat ($urandom_range(1, 5)) put_byte(8'($urandom_range(0, 255)));
            put_end();
            return;
        end
        put_byte(CH_QUOTE);
        repeat ($urandom_range(0, 6)) put_unit();
        r = $urandom_range(0, 99);
        if (r < 18) begin
            if (!put_fault()) repeat ($urandom_range(0, 2)) put_byte(8'($urandom_range(0, 255)));
        end else if (r >= 25) begin
            put_byte(CH_QUOTE);
            if ($urandom_range(0, 4) == 0) put_byte(8'($urandom_range(0, 255)));
        end
        put_end();
    endfunction

    task automatic add_tokens(input int n);
        int goal;
        goal = made_cnt + n;
        while (made_cnt < goal) add_token();
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (accepted_cnt != made_cnt || expected_words.size() != 0);
        // Items without a word may still be in the pipeline.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [23:0] value);
        @(posedge i_clk);
        cfg_if.valid   <= 1'b1;
        cfg_if.max_len <= value;
        do @(posedge i_clk);
        while (!cfg_if.ready);
        byte_limit   = value;
        cfg_if.valid <= 1'b0;
    endtask

    // Input driver.
    always @(posedge i_clk) begin
        t_in_word w;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                unescape_predict(in_if.kind, in_if.byte_in);
                accepted_cnt++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (item_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    w = item_q.pop_front();
                    in_if.valid   <= 1'b1;
                    in_if.kind    <= w.kind;
                    in_if.byte_in <= w.data;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Long output stall, started by the stimulus process.
    always @(posedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_reqs;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Output monitor and checker.
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected word: out_byte %h status %0d last %0b",
                           out_if.out_byte, out_if.status, out_if.last);
                    fail_cnt++;
                end else begin
                    want = expected_words.pop_front();
                    if (out_if.out_byte !== want.data) begin
                        $error("out_byte: expected %h, actual %h", want.data, out_if.out_byte);
                        fail_cnt++;
                    end
                    if (out_if.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, out_if.status);
                        fail_cnt++;
                    end
                    if (out_if.last !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, out_if.last);
                        fail_cnt++;
                    end
                end
            end
            out_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial begin
        in_if.valid    = 1'b0;
        in_if.kind     = 1'b0;
        in_if.byte_in  = 8'h00;
        out_if.ready   = 1'b0;
        cfg_if.valid   = 1'b0;
        cfg_if.max_len = '0;
        clear_decoder();
        byte_limit = CFG_MAX_RST;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_limit(LIMIT_TOP);
        put_end();
        put_byte(CH_QUOTE);
        put_byte("a");
        put_byte(CH_BSLASH);
        put_byte("n");
        put_byte(CH_QUOTE);
        put_byte(8'hFF);
        put_end();
        // Highest scalar value as raw bytes, then the input stops inside the body.
        put_byte(CH_QUOTE);
        put_byte(8'hF4);
        put_byte(8'h8F);
        put_byte(8'hBF);
        put_byte(8'hBF);
        put_end();
        put_byte(CH_QUOTE);
        put_u(16'hDBFF);
        put_end();
        put_byte(8'h00);
        put_end();
        wait_idle();

        set_limit(CFG_MAX_RST);
        add_tokens(25);
        wait_idle();
        set_limit('0);
        add_tokens(10);
        wait_idle();
        set_limit(24'd7);
        add_tokens(15);
        wait_idle();

        send_idle_pct = 46;
        recv_idle_pct = 34;
        set_limit(LIMIT_TOP);
        // Keep offering words while the output is held off so the input stalls.
        send_idle_pct = 0;
        hold_reqs++;
        add_tokens(20);
        wait_idle();
        send_idle_pct = 46;
        add_tokens(10);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_limit(24'($urandom_range(3, 40)));
        add_tokens(20);
        wait_idle();

        if (fail_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_if.sv
hw/rtl/jsu_decode.sv
hw/rtl/jsu_serial.sv
hw/rtl/json_string_unescape_validate.sv
tb/sv/json_string_unescape_validate_tb.sv
